/* hw/rtl/voronoi_edge_clip_and_area_macros.svh */
// Assertion macros for the edge clipper.
`ifndef VORONOI_EDGE_CLIP_AND_AREA_MACROS_SVH
`define VORONOI_EDGE_CLIP_AND_AREA_MACROS_SVH

`ifndef SYNTH
`define VECAA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("edge clipper assertion failed");
`define VECAA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("edge clipper implication failed");
`else
`define VECAA_ASSERT(lbl, prop)
`define VECAA_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

/* hw/rtl/vecaa_pkg.sv */
// Shared types, constants and helpers of the edge clipper.
package vecaa_pkg;

  localparam int unsigned CW          = 24;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int unsigned DIV_STEPS   = 25;
  localparam int unsigned DIV_LAT     = DIV_STEPS + 1;

  localparam logic signed [22:0] ONE_Q21    = 23'sd2097152;
  localparam logic signed [46:0] TRUNC_BIAS = 47'sd2097151;
  localparam logic signed [23:0] C24_MAX    = 24'sh7FFFFF;
  localparam logic signed [23:0] C24_MIN    = 24'sh800000;
  localparam logic [FIFO_AW:0]   FIFO_FULL  = (FIFO_AW + 1)'(FIFO_DEPTH);

  typedef enum logic [1:0] {
    CFG_X_LOW  = 2'd0,
    CFG_X_HIGH = 2'd1,
    CFG_Y_LOW  = 2'd2,
    CFG_Y_HIGH = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [23:0] x_low;
    logic signed [23:0] x_high;
    logic signed [23:0] y_low;
    logic signed [23:0] y_high;
  } window_t;

  typedef struct packed {
    logic signed [23:0] s0x;
    logic signed [23:0] s0y;
    logic signed [23:0] s1x;
    logic signed [23:0] s1y;
  } sites_t;

  // Queue entry: walked ends, derived ends (bound when clipped), clip flags.
  typedef struct packed {
    logic               a_one;
    logic signed [22:0] coef;
    logic signed [23:0] w1;
    logic signed [23:0] w2;
    logic signed [27:0] o1;
    logic signed [27:0] o2;
    logic               clip1;
    logic               clip2;
    logic signed [25:0] c;
    sites_t             sites;
  } edge_t;

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [23:0] r;
    if (v > 28'sd8388607) begin
      r = C24_MAX;
    end else if (v < -28'sd8388608) begin
      r = C24_MIN;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/vecaa_front.sv */
// Front end: accepts edges, walks the ends, derives the other axis, rejects and marks clips.
module vecaa_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [22:0]     line_a_i,
  input  logic signed [22:0]     line_b_i,
  input  logic signed [25:0]     line_c_i,
  input  logic [1:0]             endpoint_present_i,
  input  logic signed [23:0]     first_end_coord_i,
  input  logic signed [23:0]     second_end_coord_i,
  input  vecaa_pkg::sites_t      sites_i,
  input  vecaa_pkg::window_t     win_i,
  input  logic [vecaa_pkg::FIFO_AW:0] fifo_cnt_i,
  output logic                   push_o,
  output vecaa_pkg::edge_t       entry_o
);

  logic                  acc;
  logic [vecaa_pkg::FIFO_AW:0] occ;

  // stage 1 combinational
  logic                  a_one_d, swap_d, p1_d, p2_d, rej_w_d;
  logic signed [23:0]    c1_d, c2_d, wl_d, wh_d, w1_d, w2_d;
  logic signed [22:0]    coef_d;
  logic signed [46:0]    prod1_d, prod2_d;

  // stage 1 registers
  logic                  f1_v_q, f1_rej_q, f1_a_one_q;
  logic signed [22:0]    f1_coef_q;
  logic signed [23:0]    f1_w1_q, f1_w2_q;
  logic signed [46:0]    f1_prod1_q, f1_prod2_q;
  logic signed [25:0]    f1_c_q;
  vecaa_pkg::sites_t     f1_sites_q;

  // stage 2 combinational
  logic signed [46:0]    adj1, adj2;
  logic signed [25:0]    t1, t2;
  logic signed [27:0]    o1, o2, ol, oh, fin1, fin2;
  logic                  rej_o, clip1, clip2;

  logic                  f2_v_q, f2_v_d;
  vecaa_pkg::edge_t      f2_q, f2_d;

  assign occ        = fifo_cnt_i + {{vecaa_pkg::FIFO_AW{1'b0}}, f1_v_q}
                                 + {{vecaa_pkg::FIFO_AW{1'b0}}, f2_v_q};
  assign in_stall_o = (occ >= vecaa_pkg::FIFO_FULL);
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    a_one_d = (line_a_i == vecaa_pkg::ONE_Q21);
    swap_d  = a_one_d && !line_b_i[22];
    p1_d    = swap_d ? endpoint_present_i[1] : endpoint_present_i[0];
    p2_d    = swap_d ? endpoint_present_i[0] : endpoint_present_i[1];
    c1_d    = swap_d ? second_end_coord_i : first_end_coord_i;
    c2_d    = swap_d ? first_end_coord_i : second_end_coord_i;
    wl_d    = a_one_d ? win_i.y_low : win_i.x_low;
    wh_d    = a_one_d ? win_i.y_high : win_i.x_high;
    w1_d    = (p1_d && (c1_d > wl_d)) ? c1_d : wl_d;
    w2_d    = (p2_d && (c2_d < wh_d)) ? c2_d : wh_d;
    rej_w_d = (w1_d > wh_d) || (w2_d < wl_d);
    coef_d  = a_one_d ? line_b_i : line_a_i;
    prod1_d = 47'(coef_d) * 47'(w1_d);
    prod2_d = 47'(coef_d) * 47'(w2_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else begin
      f1_v_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      f1_rej_q   <= rej_w_d;
      f1_a_one_q <= a_one_d;
      f1_coef_q  <= coef_d;
      f1_w1_q    <= w1_d;
      f1_w2_q    <= w2_d;
      f1_prod1_q <= prod1_d;
      f1_prod2_q <= prod2_d;
      f1_c_q     <= line_c_i;
      f1_sites_q <= sites_i;
    end
  end

  always_comb begin
    // truncate toward zero when scaling back to Q.12
    adj1 = f1_prod1_q + (f1_prod1_q[46] ? vecaa_pkg::TRUNC_BIAS : 47'sd0);
    adj2 = f1_prod2_q + (f1_prod2_q[46] ? vecaa_pkg::TRUNC_BIAS : 47'sd0);
    t1   = adj1[46:21];
    t2   = adj2[46:21];
    o1   = {{2{f1_c_q[25]}}, f1_c_q} - {{2{t1[25]}}, t1};
    o2   = {{2{f1_c_q[25]}}, f1_c_q} - {{2{t2[25]}}, t2};
    ol   = f1_a_one_q ? {{4{win_i.x_low[23]}}, win_i.x_low}
                      : {{4{win_i.y_low[23]}}, win_i.y_low};
    oh   = f1_a_one_q ? {{4{win_i.x_high[23]}}, win_i.x_high}
                      : {{4{win_i.y_high[23]}}, win_i.y_high};
    rej_o = ((o1 > oh) && (o2 > oh)) || ((o1 < ol) && (o2 < ol));
    // high bound first, then low bound wins
    if (o1 > oh) begin
      fin1 = (oh < ol) ? ol : oh;
    end else if (o1 < ol) begin
      fin1 = ol;
    end else begin
      fin1 = o1;
    end
    if (o2 > oh) begin
      fin2 = (oh < ol) ? ol : oh;
    end else if (o2 < ol) begin
      fin2 = ol;
    end else begin
      fin2 = o2;
    end
    clip1 = (o1 > oh) || (o1 < ol);
    clip2 = (o2 > oh) || (o2 < ol);

    f2_d.a_one = f1_a_one_q;
    f2_d.coef  = f1_coef_q;
    f2_d.w1    = f1_w1_q;
    f2_d.w2    = f1_w2_q;
    f2_d.o1    = fin1;
    f2_d.o2    = fin2;
    f2_d.clip1 = clip1;
    f2_d.clip2 = clip2;
    f2_d.c     = f1_c_q;
    f2_d.sites = f1_sites_q;
    // drop edges wholly outside
    f2_v_d     = f1_v_q && !f1_rej_q && !rej_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_v_q <= 1'b0;
    end else begin
      f2_v_q <= f2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f1_v_q) begin
      f2_q <= f2_d;
    end
  end

  assign push_o  = f2_v_q;
  assign entry_o = f2_q;

endmodule

/* hw/rtl/vecaa_fifo.sv */
// Short queue between front and back.
module vecaa_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  vecaa_pkg::edge_t            data_i,
  input  logic                        pop_i,
  output vecaa_pkg::edge_t            head_o,
  output logic                        empty_o,
  output logic [vecaa_pkg::FIFO_AW:0] cnt_o
);

  vecaa_pkg::edge_t                 mem_q [vecaa_pkg::FIFO_DEPTH];
  logic [vecaa_pkg::FIFO_AW-1:0]    wr_q, rd_q;
  logic [vecaa_pkg::FIFO_AW:0]      cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;

endmodule

/* hw/rtl/vecaa_div.sv */
// Pipelined signed divider, one quotient bit per stage, saturating to 24 bits.
module vecaa_div (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [27:0] diff_i,
  input  logic signed [22:0] coef_i,
  output logic signed [23:0] res_o
);

  typedef struct packed {
    logic zero;
    logic sat;
    logic rneg;
    logic nneg;
  } div_flag_t;

  logic [22:0]  rem_q  [vecaa_pkg::DIV_LAT];
  logic [24:0]  low_q  [vecaa_pkg::DIV_LAT];
  logic [24:0]  quo_q  [vecaa_pkg::DIV_LAT];
  logic [22:0]  d_q    [vecaa_pkg::DIV_LAT];
  div_flag_t    flg_q  [vecaa_pkg::DIV_LAT];

  logic [27:0]  mag_w;
  logic [22:0]  d_w;
  div_flag_t    flg_d;

  // numerator is diff * 2^21; the top bits seed the remainder
  always_comb begin
    mag_w      = diff_i[27] ? 28'(-diff_i) : 28'(diff_i);
    d_w        = coef_i[22] ? 23'(-coef_i) : 23'(coef_i);
    flg_d.zero = (coef_i == '0);
    flg_d.sat  = (mag_w[26:4] >= d_w);
    flg_d.nneg = diff_i[27];
    flg_d.rneg = diff_i[27] ^ coef_i[22];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= mag_w[26:4];
      low_q[0] <= {mag_w[3:0], 21'd0};
      quo_q[0] <= '0;
      d_q[0]   <= d_w;
      flg_q[0] <= flg_d;
    end
  end

  for (genvar k = 1; k < vecaa_pkg::DIV_LAT; k++) begin : g_step
    logic [23:0] r;
    logic        ge;
    logic [23:0] sub;
    assign r   = {rem_q[k-1], low_q[k-1][24]};
    assign ge  = (r >= {1'b0, d_q[k-1]});
    assign sub = r - {1'b0, d_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? sub[22:0] : r[22:0];
        low_q[k] <= {low_q[k-1][23:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][23:0], ge};
        d_q[k]   <= d_q[k-1];
        flg_q[k] <= flg_q[k-1];
      end
    end
  end

  localparam int unsigned LAST = vecaa_pkg::DIV_LAT - 1;

  always_comb begin
    priority if (flg_q[LAST].zero) begin
      res_o = flg_q[LAST].nneg ? vecaa_pkg::C24_MIN : vecaa_pkg::C24_MAX;
    end else if (flg_q[LAST].sat) begin
      res_o = flg_q[LAST].rneg ? vecaa_pkg::C24_MIN : vecaa_pkg::C24_MAX;
    end else if (flg_q[LAST].rneg) begin
      res_o = (quo_q[LAST] > 25'd8388608) ? vecaa_pkg::C24_MIN
                                           : 24'(-quo_q[LAST]);
    end else begin
      res_o = (quo_q[LAST] > 25'd8388607) ? vecaa_pkg::C24_MAX : quo_q[LAST][23:0];
    end
  end

endmodule

/* hw/rtl/vecaa_back.sv */
// Back end: recomputes clipped ends, forms the segment and the two triangle areas.
module vecaa_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vecaa_pkg::edge_t   head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] seg_x1_o,
  output logic signed [23:0] seg_y1_o,
  output logic signed [23:0] seg_x2_o,
  output logic signed [23:0] seg_y2_o,
  output logic [47:0]        area_site0_o,
  output logic [47:0]        area_site1_o
);

  localparam int unsigned LAST = vecaa_pkg::DIV_LAT - 1;

  logic               adv;
  logic signed [27:0] diff1, diff2;
  logic signed [23:0] r1, r2;

  vecaa_pkg::edge_t   pl_q [vecaa_pkg::DIV_LAT];
  logic               pv_q [vecaa_pkg::DIV_LAT];

  logic signed [23:0] w1n, w2n, o1s, o2s;
  logic signed [23:0] sx1_q, sy1_q, sx2_q, sy2_q;
  vecaa_pkg::sites_t  ss_q;
  logic               sv_q;

  logic signed [24:0] d0x1, d0y1, d0x2, d0y2, d1x1, d1y1, d1x2, d1y2;
  logic signed [49:0] m0a_q, m0b_q, m1a_q, m1b_q;
  logic signed [23:0] mx1_q, my1_q, mx2_q, my2_q;
  logic               mv_q;

  logic signed [50:0] cr0, cr1;
  logic [50:0]        mag0, mag1;
  logic               out_v_q;

  // freeze the whole back end while a result waits
  assign adv   = !(out_v_q && out_stall_i);
  assign pop_o = adv && !empty_i;

  assign diff1 = {{2{head_i.c[25]}}, head_i.c} - head_i.o1;
  assign diff2 = {{2{head_i.c[25]}}, head_i.c} - head_i.o2;

  vecaa_div u_div1 (
    .clk_i  (clk_i),
    .en_i   (adv),
    .diff_i (diff1),
    .coef_i (head_i.coef),
    .res_o  (r1)
  );

  vecaa_div u_div2 (
    .clk_i  (clk_i),
    .en_i   (adv),
    .diff_i (diff2),
    .coef_i (head_i.coef),
    .res_o  (r2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < vecaa_pkg::DIV_LAT; k++) begin
        pv_q[k] <= 1'b0;
      end
      sv_q    <= 1'b0;
      mv_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      pv_q[0] <= !empty_i;
      for (int k = 1; k < vecaa_pkg::DIV_LAT; k++) begin
        pv_q[k] <= pv_q[k-1];
      end
      sv_q    <= pv_q[LAST];
      mv_q    <= sv_q;
      out_v_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pl_q[0] <= head_i;
      for (int k = 1; k < vecaa_pkg::DIV_LAT; k++) begin
        pl_q[k] <= pl_q[k-1];
      end
    end
  end

  always_comb begin
    w1n = pl_q[LAST].clip1 ? r1 : pl_q[LAST].w1;
    w2n = pl_q[LAST].clip2 ? r2 : pl_q[LAST].w2;
    o1s = vecaa_pkg::sat24(pl_q[LAST].o1);
    o2s = vecaa_pkg::sat24(pl_q[LAST].o2);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx1_q <= pl_q[LAST].a_one ? o1s : w1n;
      sy1_q <= pl_q[LAST].a_one ? w1n : o1s;
      sx2_q <= pl_q[LAST].a_one ? o2s : w2n;
      sy2_q <= pl_q[LAST].a_one ? w2n : o2s;
      ss_q  <= pl_q[LAST].sites;
    end
  end

  always_comb begin
    d0x1 = 25'(sx1_q) - 25'(ss_q.s0x);
    d0y1 = 25'(sy1_q) - 25'(ss_q.s0y);
    d0x2 = 25'(sx2_q) - 25'(ss_q.s0x);
    d0y2 = 25'(sy2_q) - 25'(ss_q.s0y);
    d1x1 = 25'(sx1_q) - 25'(ss_q.s1x);
    d1y1 = 25'(sy1_q) - 25'(ss_q.s1y);
    d1x2 = 25'(sx2_q) - 25'(ss_q.s1x);
    d1y2 = 25'(sy2_q) - 25'(ss_q.s1y);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m0a_q <= 50'(d0x1) * 50'(d0y2);
      m0b_q <= 50'(d0x2) * 50'(d0y1);
      m1a_q <= 50'(d1x1) * 50'(d1y2);
      m1b_q <= 50'(d1x2) * 50'(d1y1);
      mx1_q <= sx1_q;
      my1_q <= sy1_q;
      mx2_q <= sx2_q;
      my2_q <= sy2_q;
    end
  end

  always_comb begin
    cr0  = 51'(m0a_q) - 51'(m0b_q);
    cr1  = 51'(m1a_q) - 51'(m1b_q);
    mag0 = cr0[50] ? 51'(-cr0) : 51'(cr0);
    mag1 = cr1[50] ? 51'(-cr1) : 51'(cr1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      seg_x1_o     <= mx1_q;
      seg_y1_o     <= my1_q;
      seg_x2_o     <= mx2_q;
      seg_y2_o     <= my2_q;
      area_site0_o <= {10'd0, mag0[50:13]};
      area_site1_o <= {10'd0, mag1[50:13]};
    end
  end

  assign out_valid_o = out_v_q;

endmodule

/* hw/rtl/voronoi_edge_clip_and_area.sv */
// Throughput: one edge per cycle while no stall holds the flow; the back end runs a
// 26-stage divider that forms one quotient bit in each stage after the first one.
// Edges wholly outside the window are dropped in front-end stage 2 and never enter the queue.
// Reset clears all valid flags and the queue; the window resets to the full 24-bit range.
// Configuration writes are always ready and take effect on the next cycle.
`include "voronoi_edge_clip_and_area_macros.svh"

module voronoi_edge_clip_and_area (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [22:0] line_a_i,
  input  logic signed [22:0] line_b_i,
  input  logic signed [25:0] line_c_i,
  input  logic [1:0]         endpoint_present_i,
  input  logic signed [23:0] first_end_coord_i,
  input  logic signed [23:0] second_end_coord_i,
  input  logic signed [23:0] site0_x_i,
  input  logic signed [23:0] site0_y_i,
  input  logic signed [23:0] site1_x_i,
  input  logic signed [23:0] site1_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] seg_x1_o,
  output logic signed [23:0] seg_y1_o,
  output logic signed [23:0] seg_x2_o,
  output logic signed [23:0] seg_y2_o,
  output logic [47:0]        area_site0_o,
  output logic [47:0]        area_site1_o
);

  vecaa_pkg::window_t          win_q;
  vecaa_pkg::sites_t           sites;
  vecaa_pkg::edge_t            entry, head;
  logic                        fifo_push, fifo_pop, fifo_empty;
  logic [vecaa_pkg::FIFO_AW:0] fifo_cnt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.x_low  <= vecaa_pkg::C24_MIN;
      win_q.x_high <= vecaa_pkg::C24_MAX;
      win_q.y_low  <= vecaa_pkg::C24_MIN;
      win_q.y_high <= vecaa_pkg::C24_MAX;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (vecaa_pkg::cfg_idx_e'(cfg_index_i))
        vecaa_pkg::CFG_X_LOW:  win_q.x_low  <= cfg_data_i;
        vecaa_pkg::CFG_X_HIGH: win_q.x_high <= cfg_data_i;
        vecaa_pkg::CFG_Y_LOW:  win_q.y_low  <= cfg_data_i;
        vecaa_pkg::CFG_Y_HIGH: win_q.y_high <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sites.s0x = site0_x_i;
  assign sites.s0y = site0_y_i;
  assign sites.s1x = site1_x_i;
  assign sites.s1y = site1_y_i;

  vecaa_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .line_a_i           (line_a_i),
    .line_b_i           (line_b_i),
    .line_c_i           (line_c_i),
    .endpoint_present_i (endpoint_present_i),
    .first_end_coord_i  (first_end_coord_i),
    .second_end_coord_i (second_end_coord_i),
    .sites_i            (sites),
    .win_i              (win_q),
    .fifo_cnt_i         (fifo_cnt),
    .push_o             (fifo_push),
    .entry_o            (entry)
  );

  vecaa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (entry),
    .pop_i   (fifo_pop),
    .head_o  (head),
    .empty_o (fifo_empty),
    .cnt_o   (fifo_cnt)
  );

  vecaa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (fifo_empty),
    .pop_o        (fifo_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .seg_x1_o     (seg_x1_o),
    .seg_y1_o     (seg_y1_o),
    .seg_x2_o     (seg_x2_o),
    .seg_y2_o     (seg_y2_o),
    .area_site0_o (area_site0_o),
    .area_site1_o (area_site1_o)
  );

  `VECAA_ASSERT(a_fifo_no_overflow, !(fifo_push && !fifo_pop && fifo_cnt == vecaa_pkg::FIFO_FULL))
  `VECAA_ASSERT(a_pop_nonempty, !(fifo_pop && fifo_cnt == '0))
  `VECAA_ASSERT_IMP(a_stall_when_full, fifo_cnt == vecaa_pkg::FIFO_FULL, in_stall_o)

endmodule
